FILE: rtl/core/vrbm_pkg.sv
// ----------------------------------------------------------------------------
// vrbm_pkg
// Shared types and constants for the region box and mosaic pixel effect.
// ----------------------------------------------------------------------------
package vrbm_pkg;

    // field widths of the pixel stream and the register file
    localparam int COUNT_W   = 11;
    localparam int PIX_W     = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    // defaults for the top level parameters
    localparam int MAX_LINE_PIXELS_DEF = 2048;
    localparam int BLOCK_EDGE_DEF      = 8;
    localparam int PIXEL_BITS_DEF      = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

    // effect modes
    localparam logic [MODE_W-1:0] MODE_OUTLINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOSAIC  = 2'd2;

    // outline colour
    localparam logic [PIX_W-1:0] RED_WORD = 32'h00FF_0000;

    // what happens to one pixel
    typedef enum logic [1:0] {
        PX_PASS,
        PX_RED,
        PX_SAMPLE,
        PX_REPLACE
    } px_sel_t;

    typedef struct packed {
        px_sel_t sel;
    } px_ctl_t;

    // register file contents
    typedef struct packed {
        logic [COUNT_W-1:0] left;
        logic [COUNT_W-1:0] top;
        logic [COUNT_W-1:0] width;
        logic [COUNT_W-1:0] height;
        logic [MODE_W-1:0]  mode;
    } cfg_t;

endpackage

FILE: rtl/core/video_region_box_and_mosaic.sv
// ----------------------------------------------------------------------------
// video_region_box_and_mosaic
// Pixel stream effect: red outline of a rectangle or 8x8 style mosaic inside it.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tdata pixel_value, tuser frame_start, tlast line_end
//  m_*      | out       | tdata out_pixel, tuser out_frame_start, tlast out_line_end
//  cfg_*    | in        | write of left, top, width, height, mode by index
//
//  one beat per clock sustained unless the output stalls; store read stage, then output reg
//  the block sample store is read once per beat and written on sample beats at the accept edge
//  store contents are not cleared at reset; mosaic blocks take their sample
//  before they are read
//  a stalled output holds the pipe; input stalls only when both stages are full
// ----------------------------------------------------------------------------
module video_region_box_and_mosaic #(
    parameter int MAX_LINE_PIXELS = vrbm_pkg::MAX_LINE_PIXELS_DEF,
    parameter int BLOCK_EDGE      = vrbm_pkg::BLOCK_EDGE_DEF,
    parameter int PIXEL_BITS      = vrbm_pkg::PIXEL_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vrbm_pkg::PIX_W-1:0]     s_tdata,   // [31:0] pixel_value
    input  logic                           s_tuser,   // [0] frame_start
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vrbm_pkg::PIX_W-1:0]     m_tdata,   // [31:0] out_pixel
    output logic                           m_tuser,   // [0] out_frame_start
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [vrbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vrbm_pkg::CFG_W-1:0]     cfg_data
);
    import vrbm_pkg::*;

    localparam int STORE_DEPTH = MAX_LINE_PIXELS / BLOCK_EDGE;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [PIX_W-1:0] PIXEL_MASK = 32'hFFFF_FFFF >> (PIX_W - PIXEL_BITS);
    localparam logic [PIX_W-1:0] RED_OUT    = RED_WORD & PIXEL_MASK;

    cfg_t cfg_reg;

    px_ctl_t          ctl;
    logic [IDX_W-1:0] idx;
    logic             accept;
    logic             out_free;

    logic [PIXEL_BITS-1:0] store_mem [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_fs_reg;
    logic                  s1_le_reg;
    px_sel_t               s1_sel_reg;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pix_reg, m_pix_next;
    logic             m_fs_reg;
    logic             m_le_reg;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT:   cfg_reg.left   <= cfg_data;
                REG_TOP:    cfg_reg.top    <= cfg_data;
                REG_WIDTH:  cfg_reg.width  <= cfg_data;
                REG_HEIGHT: cfg_reg.height <= cfg_data;
                REG_MODE:   cfg_reg.mode   <= cfg_data[MODE_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // position tracking and classification
    vrbm_locate #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .BLOCK_EDGE      (BLOCK_EDGE)
    ) u_locate (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .frame_start (s_tuser),
        .line_end    (s_tlast),
        .cfg         (cfg_reg),
        .ctl         (ctl),
        .idx         (idx)
    );

    // block sample store: sample beats write, every beat reads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ctl.sel == PX_SAMPLE)
                store_mem[idx] <= s_tdata[PIXEL_BITS-1:0];
            rd_data_reg <= store_mem[idx];
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (out_free)
            s1_valid_reg <= 1'b0;
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= s_tdata[PIXEL_BITS-1:0];
            s1_fs_reg  <= s_tuser;
            s1_le_reg  <= s_tlast;
            s1_sel_reg <= ctl.sel;
        end
    end

    // colour selection
    always_comb
    begin
        case (s1_sel_reg)
            PX_RED:     m_pix_next = RED_OUT;
            PX_REPLACE: m_pix_next = PIX_W'(rd_data_reg);
            default:    m_pix_next = PIX_W'(s1_pix_reg);
        endcase
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_free)
            m_valid_reg <= s1_valid_reg;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            m_pix_reg <= m_pix_next;
            m_fs_reg  <= s1_fs_reg;
            m_le_reg  <= s1_le_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_fs_reg;
    assign m_tlast  = m_le_reg;

endmodule

FILE: rtl/core/vrbm_locate.sv
// ----------------------------------------------------------------------------
// vrbm_locate
// Column and row counters with block phase tracking; classifies each beat
// as pass, outline, mosaic sample or mosaic replace and gives the store index.
// ----------------------------------------------------------------------------
module vrbm_locate #(
    parameter int MAX_LINE_PIXELS = vrbm_pkg::MAX_LINE_PIXELS_DEF,
    parameter int BLOCK_EDGE      = vrbm_pkg::BLOCK_EDGE_DEF,
    localparam int STORE_DEPTH    = MAX_LINE_PIXELS / BLOCK_EDGE,
    localparam int IDX_W          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              frame_start,
    input  logic              line_end,
    input  vrbm_pkg::cfg_t    cfg,
    output vrbm_pkg::px_ctl_t ctl,
    output logic [IDX_W-1:0]  idx
);
    import vrbm_pkg::*;

    localparam int PH_W = $clog2(BLOCK_EDGE);
    localparam logic [PH_W-1:0]    PH_LAST   = PH_W'(BLOCK_EDGE - 1);
    localparam logic [COUNT_W:0]   DEPTH_CMP = (COUNT_W + 1)'(STORE_DEPTH);

    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [PH_W-1:0]    cph_reg, cph_next;
    logic [COUNT_W-1:0] cblk_reg, cblk_next;
    logic [PH_W-1:0]    rph_reg, rph_next;

    logic [COUNT_W-1:0] x, y;
    logic               at_left, at_top;
    logic [PH_W-1:0]    cph, rph;
    logic [COUNT_W-1:0] cblk;
    logic [COUNT_W:0]   right, bottom;
    logic               in_rect, on_border, blk_ok;

    // position of the current beat; frame start forces the origin
    always_comb
    begin
        x       = frame_start ? '0 : col_reg;
        y       = frame_start ? '0 : row_reg;
        at_left = (x == cfg.left);
        at_top  = (y == cfg.top);
        // block phase restarts on the rectangle's left and top edges
        cph     = at_left ? '0 : cph_reg;
        cblk    = at_left ? '0 : cblk_reg;
        rph     = at_top  ? '0 : rph_reg;
    end

    // rectangle tests, edges kept at 12 bits so they never wrap
    always_comb
    begin
        right     = {1'b0, cfg.left} + {1'b0, cfg.width};
        bottom    = {1'b0, cfg.top} + {1'b0, cfg.height};
        in_rect   = (x >= cfg.left) && ({1'b0, x} <= right) &&
                    (y >= cfg.top) && ({1'b0, y} <= bottom);
        on_border = at_left || ({1'b0, x} == right) ||
                    at_top || ({1'b0, y} == bottom);
        blk_ok    = ({1'b0, cblk} < DEPTH_CMP);
    end

    // classify the beat
    always_comb
    begin
        ctl.sel = PX_PASS;
        case (cfg.mode)
            MODE_OUTLINE:
            begin
                if (in_rect && on_border)
                    ctl.sel = PX_RED;
            end
            MODE_MOSAIC:
            begin
                if (in_rect && blk_ok)
                    ctl.sel = ((cph == '0) && (rph == '0)) ? PX_SAMPLE : PX_REPLACE;
            end
            default:
            begin
                ctl.sel = PX_PASS;
            end
        endcase
    end

    assign idx = cblk[IDX_W-1:0];

    // counter advance after the beat
    always_comb
    begin
        if (cph == PH_LAST)
        begin
            cph_next  = '0;
            cblk_next = cblk + 1'b1;
        end
        else
        begin
            cph_next  = cph + 1'b1;
            cblk_next = cblk;
        end

        if (line_end)
        begin
            col_next = '0;
            row_next = y + 1'b1;
            rph_next = (rph == PH_LAST) ? '0 : rph + 1'b1;
        end
        else
        begin
            col_next = x + 1'b1;
            row_next = y;
            rph_next = rph;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cph_reg  <= '0;
            cblk_reg <= '0;
            rph_reg  <= '0;
        end
        else if (step)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cph_reg  <= cph_next;
            cblk_reg <= cblk_next;
            rph_reg  <= rph_next;
        end
    end

endmodule

FILE: rtl/core/vrbm_checker.sv
// ----------------------------------------------------------------------------
// vrbm_checker
// Port level checks on beat ordering, occupancy and stall behavior.
// ----------------------------------------------------------------------------
module vrbm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [vrbm_pkg::PIX_W-1:0] m_tdata,
    input logic                       m_tuser,
    input logic                       m_tlast
);
    import vrbm_pkg::*;

    logic [2:0] pending_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_beat && !out_beat)
            pending_reg <= pending_reg + 1'b1;
        else if (!in_beat && out_beat)
            pending_reg <= pending_reg - 1'b1;
    end

    // a stalled output beat holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // no output beat without an accepted input beat behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("output beat with no pending input");

    // at most two beats in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more beats in flight than pipeline stages");

    // input stalls only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

endmodule

bind video_region_box_and_mosaic vrbm_checker u_vrbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
